>>> hdl/tafk_pkg.sv
// Package for the three-axis forward kinematics block: payload structs,
// CORDIC constants and the arctangent table. No dependencies.
`default_nettype none
package tafk_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;
  localparam logic signed [25:0] POS_MAX = 26'sd8388607;
  localparam logic signed [25:0] POS_MIN = -26'sd8388608;

  localparam logic [0:0] REG_TOOL_LENGTH = 1'b0;
  localparam logic [0:0] REG_BASE_HEIGHT = 1'b1;
  localparam int CFG_IDX_W = 2;

  typedef struct packed {
    logic signed [15:0] base_angle;
    logic signed [15:0] slide_offset;
    logic signed [15:0] wrist_angle;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [23:0] pos_x;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [23:0] pos_y;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [23:0] pos_z;
  } out_req_t;

  function automatic logic signed [33:0] atan_turn32(input int i);
    logic signed [33:0] v;
    begin
      case (i)
        0: v = 34'sd536870912;
        1: v = 34'sd316933406;
        2: v = 34'sd167458907;
        3: v = 34'sd85004756;
        4: v = 34'sd42667331;
        5: v = 34'sd21354465;
        6: v = 34'sd10679838;
        7: v = 34'sd5340245;
        8: v = 34'sd2670163;
        9: v = 34'sd1335087;
        10: v = 34'sd667544;
        11: v = 34'sd333772;
        12: v = 34'sd166886;
        13: v = 34'sd83443;
        14: v = 34'sd41722;
        15: v = 34'sd20861;
        16: v = 34'sd10430;
        17: v = 34'sd5215;
        18: v = 34'sd2608;
        19: v = 34'sd1304;
        20: v = 34'sd652;
        21: v = 34'sd326;
        22: v = 34'sd163;
        23: v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/three_axis_forward_kinematics.sv
// Top level of the three-axis forward kinematics block: two CORDIC pipelines,
// product stage and position stage. Depends on tafk_pkg and tafk_cordic.
//
// One joint set is taken every cycle (busy is always low after reset); each
// result passes through the unrolled CORDIC pipeline and its rounding stage,
// then the product and position stages. The receiver cannot stall, so
// out_valid strobes once per request.
`default_nettype none
module three_axis_forward_kinematics #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire tafk_pkg::in_req_t             in_req,
  output logic                               out_valid,
  output tafk_pkg::out_req_t                 out_req,
  input  wire logic                          cfg_we,
  input  wire logic [tafk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [17:0]                   cfg_data
);
  import tafk_pkg::*;

  localparam int LAT = ((CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES) + 2;

  logic [15:0] tool_length_r;
  logic [17:0] base_height_r;
  logic        acc;

  assign busy = 1'b0;
  assign acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tool_length_r <= 16'd6400;
      base_height_r <= 18'd28160;
    end else if (cfg_we && cfg_index[CFG_IDX_W-1:1] == '0) begin
      if (cfg_index[0] == REG_TOOL_LENGTH) tool_length_r <= cfg_data[15:0];
      else if (cfg_index[0] == REG_BASE_HEIGHT) base_height_r <= cfg_data;
    end
  end

  logic               vb, vw;
  logic signed [17:0] sb, cb, sw, cw;

  tafk_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_base (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_angle(in_req.base_angle),
    .out_valid(vb), .out_sin(sb), .out_cos(cb));

  tafk_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_wrist (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_angle(in_req.wrist_angle),
    .out_valid(vw), .out_sin(sw), .out_cos(cw));

  logic signed [15:0] slide_r [0:LAT-1];
  always_ff @(posedge clk) begin
    slide_r[0] <= in_req.slide_offset;
    for (int i = 1; i < LAT; i++) slide_r[i] <= slide_r[i-1];
  end

  function automatic logic signed [17:0] rmul(input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    logic signed [35:0] p;
    begin
      p = (a * b + 36'sd8192) >>> 14;
      return p[17:0];
    end
  endfunction

  // stage A: rotation products
  logic               va_r;
  logic signed [17:0] r00_r, r01_r, r10_r, r11_r, sb_a_r, cb_a_r, sw_a_r, cw_a_r;
  logic signed [15:0] sl_a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= vb;
    r00_r <= rmul(cb, sw);
    r01_r <= rmul(cb, cw);
    r10_r <= rmul(sb, sw);
    r11_r <= rmul(sb, cw);
    sb_a_r <= sb; cb_a_r <= cb; sw_a_r <= sw; cw_a_r <= cw;
    sl_a_r <= slide_r[LAT-1];
  end

  function automatic logic signed [25:0] tmul(input logic [15:0] t,
                                              input logic signed [17:0] v);
    logic signed [35:0] p;
    begin
      p = ($signed({2'b00, t}) * v + 36'sd8192) >>> 14;
      return p[25:0];
    end
  endfunction

  function automatic logic signed [23:0] sat(input logic signed [25:0] v);
    logic signed [23:0] r;
    begin
      if (v > POS_MAX) r = POS_MAX[23:0];
      else if (v < POS_MIN) r = POS_MIN[23:0];
      else r = v[23:0];
      return r;
    end
  endfunction

  // stage B: tool length products
  logic               vp_r;
  logic signed [25:0] px_r, py_r, pz_r;
  logic signed [17:0] r00_b, r01_b, r10_b, r11_b, sb_b, cb_b, sw_b, cw_b;
  logic signed [15:0] sl_b;
  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else vp_r <= va_r;
    px_r <= tmul(tool_length_r, r00_r);
    py_r <= tmul(tool_length_r, r10_r);
    pz_r <= tmul(tool_length_r, cw_a_r);
    r00_b <= r00_r; r01_b <= r01_r; r10_b <= r10_r; r11_b <= r11_r;
    sb_b <= sb_a_r; cb_b <= cb_a_r; sw_b <= sw_a_r; cw_b <= cw_a_r;
    sl_b <= sl_a_r;
  end

  // stage C: sums, saturation and output register
  logic               vo_r;
  out_req_t           out_r, out_nxt;
  logic signed [25:0] z_sum;
  always_comb begin
    z_sum = pz_r + 26'(sl_b) + $signed({8'd0, base_height_r});
    out_nxt.r00 = r00_b[15:0];
    out_nxt.r01 = r01_b[15:0];
    out_nxt.r02 = 16'(-sb_b);
    out_nxt.pos_x = sat(px_r);
    out_nxt.r10 = r10_b[15:0];
    out_nxt.r11 = r11_b[15:0];
    out_nxt.r12 = cb_b[15:0];
    out_nxt.pos_y = sat(py_r);
    out_nxt.r20 = cw_b[15:0];
    out_nxt.r21 = 16'(-sw_b);
    out_nxt.r22 = '0;
    out_nxt.pos_z = sat(z_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else vo_r <= vp_r;
    out_r <= out_nxt;
  end

  assign out_valid = vo_r;
  assign out_req = out_r;

`ifndef SYNTH
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    vb == vw) else $error("cordic pipelines out of step");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_req.r22 == 16'sd0) else $error("r22 not zero");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |=> ##1 vo_r) else $error("request lost in output stages");
`endif
endmodule
`default_nettype wire

>>> hdl/tafk_cordic.sv
// Pipelined rotation-mode CORDIC: one stage per register, sine and cosine in Q1.14.
// Depends on tafk_pkg.
`default_nettype none
module tafk_cordic #(
  parameter int STAGES = 16,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] in_angle,
  output logic                    out_valid,
  output logic signed [17:0]      out_sin,
  output logic signed [17:0]      out_cos
);
  import tafk_pkg::*;

  localparam int N = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

  logic               vld_r [0:N];
  logic signed [33:0] x_r   [0:N];
  logic signed [33:0] y_r   [0:N];
  logic signed [33:0] z_r   [0:N];
  logic               flp_r [0:N];

  logic [31:0]        a_fld;
  logic [31:0]        a_nxt;
  logic signed [33:0] z_nxt;
  logic               flp_nxt;

  always_comb begin
    a_fld = {16'd0, in_angle} & ((32'd1 << ANGLE_BITS) - 32'd1);
    a_nxt = a_fld << (32 - ANGLE_BITS);
    z_nxt = {{2{a_nxt[31]}}, a_nxt};
    flp_nxt = (z_nxt > 34'sd1073741824) || (z_nxt < -34'sd1073741824);
    if (flp_nxt) begin
      if (z_nxt < 0) z_nxt = z_nxt + 34'sd2147483648;
      else z_nxt = z_nxt - 34'sd2147483648;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_valid;
    x_r[0] <= INV_GAIN_Q30;
    y_r[0] <= '0;
    z_r[0] <= z_nxt;
    flp_r[0] <= flp_nxt;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else vld_r[i+1] <= vld_r[i];
      flp_r[i+1] <= flp_r[i];
      if (!z_r[i][33]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_turn32(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_turn32(i);
      end
    end
  end

  function automatic logic signed [17:0] rnd(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] r;
    begin
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384) r = ONE_Q14;
      else if (t < -34'sd16384) r = -ONE_Q14;
      else r = t[17:0];
      return r;
    end
  endfunction

  logic signed [17:0] s_r, c_r;
  logic               v_r;
  logic signed [17:0] s_nxt, c_nxt;

  always_comb begin
    s_nxt = rnd(y_r[N]);
    c_nxt = rnd(x_r[N]);
    if (flp_r[N]) begin
      s_nxt = -s_nxt;
      c_nxt = -c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= vld_r[N];
    s_r <= s_nxt;
    c_r <= c_nxt;
  end

  assign out_valid = v_r;
  assign out_sin = s_r;
  assign out_cos = c_r;

`ifndef SYNTH
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N] |=> v_r) else $error("cordic valid lost");
  a_sin: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (s_r <= ONE_Q14 && s_r >= -ONE_Q14)) else $error("sine out of range");
  a_cos: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (c_r <= ONE_Q14 && c_r >= -ONE_Q14)) else $error("cosine out of range");
`endif
endmodule
`default_nettype wire

>>> tb/sv/three_axis_forward_kinematics_check.sv
// Checker for the three-axis forward kinematics block: watches requests,
// register writes and results, predicts each pose and compares it.
// Depends on tafk_pkg.
`timescale 1ns / 100ps
module three_axis_forward_kinematics_check (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire tafk_pkg::in_req_t              in_req,
  input  wire logic                           out_valid,
  input  wire tafk_pkg::out_req_t             out_req,
  input  wire logic                           cfg_we,
  input  wire logic [tafk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [17:0]                    cfg_data,
  output int                                  pending,
  output int                                  errors
);
  import tafk_pkg::*;

  localparam int STAGES = 16;
  localparam longint ARCTAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic [15:0] tool_len;
  logic [17:0] base_hgt;
  out_req_t    pose_q[$];

  assign pending = pose_q.size();

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic sin_cos(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    longint      z, x, y, nx;
    bit          flip;
    a = {ang, 16'h0000};
    z = longint'($signed(a));
    flip = 0;
    x = 652032874;
    y = 0;
    if (z > (longint'(1) << 30) || z < -(longint'(1) << 30)) begin
      flip = 1;
      z = z < 0 ? z + (longint'(1) << 31) : z - (longint'(1) << 31);
    end
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARCTAN[i];
      end
      x = nx;
    end
    c = clip(rnd_shift(x, 16), -16384, 16384);
    s = clip(rnd_shift(y, 16), -16384, 16384);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  task automatic predict_pose(input in_req_t r, output out_req_t p);
    longint sb, cb, sw, cw, tl, a00, a10;
    sin_cos(r.base_angle, sb, cb);
    sin_cos(r.wrist_angle, sw, cw);
    tl = longint'(tool_len);
    a00 = rnd_shift(cb * sw, 14);
    a10 = rnd_shift(sb * sw, 14);
    p.r00 = a00[15:0];
    p.r01 = 16'(rnd_shift(cb * cw, 14));
    p.r02 = 16'(-sb);
    p.pos_x = 24'(clip(rnd_shift(tl * a00, 14), -8388608, 8388607));
    p.r10 = a10[15:0];
    p.r11 = 16'(rnd_shift(sb * cw, 14));
    p.r12 = 16'(cb);
    p.pos_y = 24'(clip(rnd_shift(tl * a10, 14), -8388608, 8388607));
    p.r20 = 16'(cw);
    p.r21 = 16'(-sw);
    p.r22 = '0;
    p.pos_z = 24'(clip(rnd_shift(tl * cw, 14) + longint'(r.slide_offset)
                       + longint'(base_hgt), -8388608, 8388607));
  endtask

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic cmp(input string what, input logic [23:0] got, input logic [23:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk) begin
    out_req_t p;
    if (!rst_n) begin
      tool_len <= 16'd6400;
      base_hgt <= 18'd28160;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_W'(REG_TOOL_LENGTH)) tool_len <= cfg_data[15:0];
        else if (cfg_index == CFG_IDX_W'(REG_BASE_HEIGHT)) base_hgt <= cfg_data;
      end
      if (start && !busy) begin
        predict_pose(in_req, p);
        pose_q.push_back(p);
      end
      if (out_valid) begin
        if (pose_q.size() == 0) begin
          report("unexpected", 24'(out_req.r00), 24'h0);
        end else begin
          p = pose_q.pop_front();
          cmp("r00", 24'(out_req.r00), 24'(p.r00));
          cmp("r01", 24'(out_req.r01), 24'(p.r01));
          cmp("r02", 24'(out_req.r02), 24'(p.r02));
          cmp("pos_x", out_req.pos_x, p.pos_x);
          cmp("r10", 24'(out_req.r10), 24'(p.r10));
          cmp("r11", 24'(out_req.r11), 24'(p.r11));
          cmp("r12", 24'(out_req.r12), 24'(p.r12));
          cmp("pos_y", out_req.pos_y, p.pos_y);
          cmp("r20", 24'(out_req.r20), 24'(p.r20));
          cmp("r21", 24'(out_req.r21), 24'(p.r21));
          cmp("r22", 24'(out_req.r22), 24'(p.r22));
          cmp("pos_z", out_req.pos_z, p.pos_z);
        end
      end
    end
  end
endmodule

>>> tb/sv/three_axis_forward_kinematics_test.sv
// Top of the forward kinematics testbench: clock, reset, register writes and
// joint-set requests. Depends on tafk_pkg, the block and its checker.
`timescale 1ns / 100ps
module three_axis_forward_kinematics_test;
  import tafk_pkg::*;

  localparam int LIMIT = 200000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_req_t out_req;
  logic     cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [17:0] cfg_data;
  int       pending;
  int       errors;
  int       cycles;

  three_axis_forward_kinematics uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_req(out_req), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data));

  three_axis_forward_kinematics_check chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_req(out_req), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .pending(pending),
    .errors(errors));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input in_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] tl, input logic [17:0] bh);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(REG_TOOL_LENGTH);
    cfg_data <= {2'($urandom), tl};
    @(posedge clk);
    cfg_index <= CFG_IDX_W'(REG_BASE_HEIGHT);
    cfg_data <= bh;
    @(posedge clk);
    cfg_index <= CFG_IDX_W'(2);
    cfg_data <= 18'($urandom);
    @(posedge clk);
    cfg_index <= CFG_IDX_W'(3);
    cfg_data <= 18'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle;
    logic [15:0] edges [6] = '{16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h0000, 16'h4001};
    if ($urandom_range(9) == 0) return edges[$urandom_range(5)] + 16'($urandom_range(4)) - 16'd2;
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] angs [10] = '{16'h0000, 16'h4000, 16'hC000, 16'h4001, 16'hBFFF,
                               16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h2000};
    in_req_t r;
    int idle;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 10; i++) begin
      r.base_angle = angs[i];
      r.wrist_angle = angs[9 - i];
      r.slide_offset = (i % 2) ? 16'h8000 : 16'h7FFF;
      send(r, 0);
    end
    drain();
    configure(16'hFFFF, 18'h3FFFF);
    for (int i = 0; i < 10; i++) begin
      r.base_angle = angs[(i * 3) % 10];
      r.wrist_angle = angs[i];
      r.slide_offset = (i % 2) ? 16'h7FFF : 16'h8000;
      send(r, 0);
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: configure(16'h0000, 18'h00000);
        1: configure(16'($urandom), 18'($urandom));
        default: configure(16'hFFFF, 18'h3FFFF);
      endcase
      idle = ph == 0 ? 13 : (ph == 1 ? 78 : 0);
      for (int i = 0; i < 250; i++) begin
        if (ph == 0 && i == 125) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        r.base_angle = pick_angle();
        r.wrist_angle = pick_angle();
        r.slide_offset = 16'($urandom);
        send(r, idle);
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
